// ===== src/u8pd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8pd_pkg: shared types and constants of the printable UTF-8 decoder
// Holds the transaction structs of both channels and the code point limits.
// ----------------------------------------------------------------------------
package u8pd_pkg;

  localparam int unsigned CpW = 21;

  // Code point limits
  localparam logic [CpW-1:0] CpMax        = 21'h10FFFF;
  localparam logic [CpW-1:0] CpSpace      = 21'h000020;
  localparam logic [CpW-1:0] CpDel        = 21'h00007F;
  localparam logic [CpW-1:0] CpC1Lo       = 21'h000080;
  localparam logic [CpW-1:0] CpC1Hi       = 21'h00009F;
  localparam logic [CpW-1:0] CpSurrLo     = 21'h00D800;
  localparam logic [CpW-1:0] CpSurrHi     = 21'h00DFFF;
  localparam logic [CpW-1:0] CpNonCharLo  = 21'h00FDD0;
  localparam logic [CpW-1:0] CpNonCharHi  = 21'h00FDEF;
  localparam logic [15:0]    CpPlaneEndLo = 16'hFFFE;
  localparam logic [15:0]    CpPlaneEndHi = 16'hFFFF;
  localparam logic [CpW-1:0] CpMin2       = 21'h000080;
  localparam logic [CpW-1:0] CpMin3       = 21'h000800;
  localparam logic [CpW-1:0] CpMin4       = 21'h010000;

  // Sequence length minus one
  localparam logic [1:0] SeqLen1 = 2'd0;
  localparam logic [1:0] SeqLen2 = 2'd1;
  localparam logic [1:0] SeqLen3 = 2'd2;
  localparam logic [1:0] SeqLen4 = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           invalid;
    logic           text_end;
  } out_t;

endpackage

// ===== src/utf8_printable_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_printable_decoder: byte-wise UTF-8 decoder for printable text
// Gathers multi-byte sequences and emits one transaction per completed code
// point or per error; drops the rest of a text after an error.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o   | in_data_i  (in_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_t)
//
// One byte is taken per cycle unless the output stalls; a taken byte waits in
// the input register and is decoded when the result register is free or
// draining, and out_valid_o rises as a completed result is loaded there.
// The input register frees as the result register drains, so a stalled
// output blocks input only once both registers are full.
// rst_ni clears the sequence state and both valid flags.
// ----------------------------------------------------------------------------
module utf8_printable_decoder import u8pd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic           in_vld_q, in_vld_d;
  in_t            in_data_q;
  logic           out_vld_q, out_vld_d;
  out_t           out_data_q, out_data_d;
  logic [CpW-1:0] pv_q, pv_d;
  logic [1:0]     rem_q, rem_d;
  logic [1:0]     len_q, len_d;
  logic           disc_q, disc_d;
  logic           adv;
  logic           res_vld;
  logic [CpW-1:0] pv_next;
  logic           cp_bad;
  logic [CpW-1:0] chk_value;
  logic [1:0]     chk_len;
  logic [7:0]     b;
  logic           last;

  assign b    = in_data_q.data_byte;
  assign last = in_data_q.end_of_text;

  // Advance the held byte when the result slot is free or draining
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  assign pv_next   = {pv_q[CpW-7:0], b[5:0]};
  assign chk_value = (rem_q == 2'd0) ? {13'd0, b} : pv_next;
  assign chk_len   = (rem_q == 2'd0) ? SeqLen1 : len_q;

  u8pd_check u_check (
    .value_i   (chk_value),
    .seq_len_i (chk_len),
    .bad_o     (cp_bad)
  );

  // Decode one byte against the sequence state
  always_comb begin
    pv_d       = pv_q;
    rem_d      = rem_q;
    len_d      = len_q;
    disc_d     = disc_q;
    res_vld    = 1'b0;
    out_data_d = '{code_point: '0, invalid: 1'b1, text_end: last};

    if (disc_q) begin
      if (last) begin
        disc_d = 1'b0;
        pv_d   = '0;
        rem_d  = '0;
        len_d  = '0;
      end
    end else if (rem_q == 2'd0) begin
      if (b[7] == 1'b0) begin
        res_vld                = 1'b1;
        out_data_d.invalid     = cp_bad;
        out_data_d.code_point  = cp_bad ? '0 : chk_value;
      end else if (b[7:5] == 3'b110) begin
        pv_d  = {16'd0, b[4:0]};
        rem_d = 2'd1;
        len_d = SeqLen2;
        res_vld = last;
      end else if (b[7:4] == 4'b1110) begin
        pv_d  = {17'd0, b[3:0]};
        rem_d = 2'd2;
        len_d = SeqLen3;
        res_vld = last;
      end else if (b[7:3] == 5'b11110) begin
        pv_d  = {18'd0, b[2:0]};
        rem_d = 2'd3;
        len_d = SeqLen4;
        res_vld = last;
      end else begin
        res_vld = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      res_vld = 1'b1;
    end else begin
      pv_d  = pv_next;
      rem_d = rem_q - 2'd1;
      if (rem_q == 2'd1) begin
        res_vld               = 1'b1;
        out_data_d.invalid    = cp_bad;
        out_data_d.code_point = cp_bad ? '0 : pv_next;
      end else begin
        res_vld = last;
      end
    end

    // Close the sequence on any result
    if (res_vld) begin
      pv_d   = '0;
      rem_d  = '0;
      len_d  = '0;
      disc_d = out_data_d.invalid && !last;
    end
  end

  // Hold the input byte until it advances
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  // Load the result slot on advance, drop it when taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = res_vld;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pv_q      <= '0;
      rem_q     <= '0;
      len_q     <= '0;
      disc_q    <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        pv_q   <= pv_d;
        rem_q  <= rem_d;
        len_q  <= len_d;
        disc_q <= disc_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (adv && res_vld) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/u8pd_check.sv =====
// ----------------------------------------------------------------------------
// u8pd_check: validity test of a completed code point
// Flags overlong forms and values that are not printable.
// ----------------------------------------------------------------------------
module u8pd_check import u8pd_pkg::*; (
  input  logic [CpW-1:0] value_i,
  input  logic [1:0]     seq_len_i,
  output logic           bad_o
);

  logic [CpW-1:0] minimum;
  logic           unprintable;

  // Pick the smallest value allowed for the sequence length
  always_comb begin
    case (seq_len_i)
      SeqLen2: minimum = CpMin2;
      SeqLen3: minimum = CpMin3;
      SeqLen4: minimum = CpMin4;
      default: minimum = '0;
    endcase
  end

  // Reject controls, C1, surrogates, out of range and noncharacters
  assign unprintable = (value_i < CpSpace) || (value_i == CpDel) ||
                       (value_i >= CpC1Lo && value_i <= CpC1Hi) ||
                       (value_i >= CpSurrLo && value_i <= CpSurrHi) ||
                       (value_i > CpMax) ||
                       (value_i >= CpNonCharLo && value_i <= CpNonCharHi) ||
                       (value_i[15:0] == CpPlaneEndLo) ||
                       (value_i[15:0] == CpPlaneEndHi);

  assign bad_o = (value_i < minimum) || unprintable;

endmodule

// ===== src/u8pd_checker.sv =====
// ----------------------------------------------------------------------------
// u8pd_props: port-level checks of the printable UTF-8 decoder
// Watches results for legal values, a stable stall and input readiness.
// ----------------------------------------------------------------------------
module u8pd_props import u8pd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // Error results carry a zero code point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.invalid |-> out_data_o.code_point == '0)
    else $error("invalid result with nonzero code point");

  // Good results stay within the scalar range and outside surrogates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.invalid |->
      out_data_o.code_point <= CpMax &&
      (out_data_o.code_point < CpSurrLo || out_data_o.code_point > CpSurrHi))
    else $error("good result outside the scalar range");

  // Good results are never C0 control characters or DEL
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.invalid |->
      out_data_o.code_point >= CpSpace && out_data_o.code_point != CpDel)
    else $error("good result is a control character");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Accept input whenever the result slot is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with an empty result slot");

endmodule

bind utf8_printable_decoder u8pd_props u_u8pd_props (.*);

// ===== verif/u8pd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u8pd_checker: scoreboard for the printable UTF-8 decoder
// Watches both channels, decodes every accepted byte with its own copy of the
// sequence state, and compares each result transaction with the oldest
// predicted one. Reports mismatches and the number of results still owed.
// ----------------------------------------------------------------------------
module u8pd_checker import u8pd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned rejects_o
);

  out_t           decoded_q[$];
  out_t           want;
  logic [CpW-1:0] partial    = '0;
  logic [1:0]     conts_left = '0;
  logic [1:0]     seq_len    = SeqLen1;
  logic           dropping   = 1'b0;
  int unsigned    mismatches = 0;
  int unsigned    backlog    = 0;
  int unsigned    results    = 0;
  int unsigned    rejects    = 0;

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = backlog;
  assign results_o      = results;
  assign rejects_o      = rejects;

  // Printable: no controls, no C1, no surrogates, no noncharacters, in range
  function automatic logic printable(input logic [CpW-1:0] v);
    logic [15:0] lo;
    lo = v[15:0];
    if (v < CpSpace || v == CpDel) return 1'b0;
    if (v >= CpC1Lo && v <= CpC1Hi) return 1'b0;
    if (v >= CpSurrLo && v <= CpSurrHi) return 1'b0;
    if (v > CpMax) return 1'b0;
    if (v >= CpNonCharLo && v <= CpNonCharHi) return 1'b0;
    if (lo == CpPlaneEndLo || lo == CpPlaneEndHi) return 1'b0;
    return 1'b1;
  endfunction

  // Queue one result and clear the sequence; an error mid text starts dropping
  task automatic post(input logic [CpW-1:0] cp, input logic bad, input logic last);
    out_t item;
    item       = '{code_point: bad ? '0 : cp, invalid: bad, text_end: last};
    decoded_q  = {decoded_q, item};
    partial    = '0;
    conts_left = '0;
    seq_len    = SeqLen1;
    dropping   = bad && !last;
  endtask

  // Advance the decoder by one byte
  task automatic decode_byte(input in_t t);
    logic [CpW-1:0] floor;
    if (dropping) begin
      if (t.end_of_text) dropping = 1'b0;
    end else if (conts_left == 2'd0) begin
      casez (t.data_byte)
        8'b0???????: post({13'd0, t.data_byte}, !printable({13'd0, t.data_byte}),
                          t.end_of_text);
        8'b110?????: begin
          partial    = {16'd0, t.data_byte[4:0]};
          conts_left = 2'd1;
          seq_len    = SeqLen2;
        end
        8'b1110????: begin
          partial    = {17'd0, t.data_byte[3:0]};
          conts_left = 2'd2;
          seq_len    = SeqLen3;
        end
        8'b11110???: begin
          partial    = {18'd0, t.data_byte[2:0]};
          conts_left = 2'd3;
          seq_len    = SeqLen4;
        end
        default: post('0, 1'b1, t.end_of_text);
      endcase
      // A lead byte that ends the text leaves the sequence cut off
      if (conts_left != 2'd0 && t.end_of_text) post('0, 1'b1, 1'b1);
    end else if (t.data_byte[7:6] != 2'b10) begin
      post('0, 1'b1, t.end_of_text);
    end else begin
      partial    = {partial[CpW-7:0], t.data_byte[5:0]};
      conts_left = conts_left - 2'd1;
      if (conts_left == 2'd0) begin
        case (seq_len)
          SeqLen2: floor = CpMin2;
          SeqLen3: floor = CpMin3;
          default: floor = CpMin4;
        endcase
        post(partial, partial < floor || !printable(partial), t.end_of_text);
      end else if (t.end_of_text) begin
        post('0, 1'b1, 1'b1);
      end
    end
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decoded_q.delete();
      partial    = '0;
      conts_left = '0;
      seq_len    = SeqLen1;
      dropping   = 1'b0;
    end else begin
      if (in_valid_i && in_ready_i) decode_byte(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: code_point %h invalid %b text_end %b",
                 out_data_i.code_point, out_data_i.invalid, out_data_i.text_end);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          results++;
          if (want.invalid) rejects++;
          if (out_data_i.code_point !== want.code_point) begin
            $error("code_point mismatch: expected %h, got %h",
                   want.code_point, out_data_i.code_point);
            mismatches++;
          end
          if (out_data_i.invalid !== want.invalid) begin
            $error("invalid mismatch: expected %b, got %b",
                   want.invalid, out_data_i.invalid);
            mismatches++;
          end
          if (out_data_i.text_end !== want.text_end) begin
            $error("text_end mismatch: expected %b, got %b",
                   want.text_end, out_data_i.text_end);
            mismatches++;
          end
        end
      end
    end
    backlog = decoded_q.size();
  end

endmodule

// ===== verif/tb_utf8_printable_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_printable_decoder: stimulus and verdict for the UTF-8 decoder
// Sends a short directed set of texts covering several error kinds, then
// random texts built mostly from well-formed sequences, some near the
// printable limits, with bursty input and a stalling receiver. A checker
// module does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_utf8_printable_decoder;
  import u8pd_pkg::*;

  localparam int unsigned RandomBytes = 1600;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 10;

  // How a generated sequence is damaged
  localparam int SeqWhole  = 0;
  localparam int SeqCut    = 1;
  localparam int SeqBroken = 2;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned results;
  int unsigned rejects;
  int unsigned burst_left  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned texts_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_run      = 0;
  logic        rx_level    = 1'b0;
  logic [7:0]  text_q[$];

  utf8_printable_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  u8pd_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending),
    .results_o     (results),
    .rejects_o     (rejects)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: mostly ready, short stalls, now and then a long stall-free run
  always @(negedge clk_i) begin
    if (rx_run == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        rx_level = 1'b1;
        rx_run   = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 24);
      end else begin
        rx_level = 1'b0;
        rx_run   = $urandom_range(1, 8);
      end
    end
    rx_run--;
    out_ready_i <= rx_level;
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles", StallLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [CpW-1:0] min_for(input int unsigned n);
    case (n)
      2:       return CpMin2;
      3:       return CpMin3;
      default: return CpMin4;
    endcase
  endfunction

  function automatic logic [CpW-1:0] any_cp(input int unsigned n);
    case (n)
      2:       return CpW'($urandom_range(CpMin2, CpMin3 - 1));
      3:       return CpW'($urandom_range(CpMin3, CpMin4 - 1));
      default: return CpW'($urandom_range(CpMin4, CpMax));
    endcase
  endfunction

  function automatic int unsigned natural_len(input logic [CpW-1:0] cp);
    if (cp < CpMin2) return 1;
    if (cp < CpMin3) return 2;
    if (cp < CpMin4) return 3;
    return 4;
  endfunction

  // Values one step around the printable limits
  function automatic logic [CpW-1:0] near_boundary();
    logic [CpW-1:0] base;
    case ($urandom_range(0, 13))
      0:       base = CpSpace;
      1:       base = CpDel;
      2:       base = CpC1Lo;
      3:       base = CpC1Hi + 21'd1;
      4:       base = CpMin3;
      5:       base = CpSurrLo;
      6:       base = CpSurrHi + 21'd1;
      7:       base = CpNonCharLo;
      8:       base = CpNonCharHi + 21'd1;
      9:       base = 21'h00FFFE;
      10:      base = CpMin4;
      11:      base = 21'h01FFFE;
      12:      base = CpMax - 21'd1;
      default: base = CpMax + 21'd1;
    endcase
    return CpW'(base - 21'd1 + $urandom_range(0, 2));
  endfunction

  // Encode cp in n bytes (overlong allowed), optionally cut or broken
  task automatic append_seq(input logic [CpW-1:0] cp, input int unsigned n, input int mode);
    logic [7:0]  seq[4];
    logic [7:0]  junk;
    int unsigned keep;
    case (n)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    keep = n;
    if (mode == SeqCut) keep = $urandom_range(1, n - 1);
    if (mode == SeqBroken) begin
      junk = 8'($urandom_range(0, 255));
      if (junk[7:6] == 2'b10) junk[6] = 1'b1;
      seq[$urandom_range(1, n - 1)] = junk;
    end
    for (int i = 0; i < keep; i++) text_q = {text_q, seq[i]};
  endtask

  // Build one random text, mostly well-formed with some noise
  task automatic compose_text();
    int unsigned    nchar;
    int unsigned    r;
    int unsigned    n;
    logic [CpW-1:0] cp;
    nchar = $urandom_range(1, 8);
    repeat (nchar) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        append_seq(CpW'($urandom_range(32, 126)), 1, SeqWhole);
      end else if (r < 32) begin
        append_seq(CpW'($urandom_range(0, 127)), 1, SeqWhole);
      end else if (r < 68) begin
        n = $urandom_range(2, 4);
        append_seq(any_cp(n), n, SeqWhole);
      end else if (r < 80) begin
        cp = near_boundary();
        append_seq(cp, natural_len(cp), SeqWhole);
      end else if (r < 84) begin
        n = $urandom_range(2, 4);
        append_seq(CpW'($urandom_range(0, min_for(n) - 1)), n, SeqWhole);
      end else if (r < 87) begin
        append_seq(CpW'($urandom_range(CpMax + 1, 21'h1FFFFF)), 4, SeqWhole);
      end else if (r < 91) begin
        text_q = {text_q, 8'($urandom_range(0, 255))};
      end else begin
        n = $urandom_range(2, 4);
        append_seq(any_cp(n), n, (r < 95) ? SeqCut : SeqBroken);
      end
    end
  endtask

  // Drive one byte, with random gaps between bursts
  task automatic push_byte(input logic [7:0] b, input logic eot);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, end_of_text: eot};
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  // Send the queued text, marking its last byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) push_byte(text_q[i], i == text_q.size() - 1);
    bytes_sent += text_q.size();
    texts_sent++;
    text_q.delete();
  endtask

  // Hold the input until every predicted result has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned base;
    logic        paused;
    paused = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Printable ASCII limits, a control byte with the rest dropped, then DEL
    text_q = {8'h20, 8'h7E};                    send_text();
    text_q = {8'h00, 8'hFF};                    send_text();
    text_q = {8'h7F};                           send_text();
    // Good two-byte form, then an overlong one at the end of the text
    text_q = {8'hC2, 8'hA0, 8'hC1, 8'hBF};      send_text();
    // Bad lead bytes
    text_q = {8'hF8};                           send_text();
    text_q = {8'h80};                           send_text();
    // Bad continuation mid text, trailing byte dropped
    text_q = {8'hE2, 8'h41, 8'h41};             send_text();
    // Highest printable four-byte value, then one above the range
    text_q = {8'hF4, 8'h8F, 8'hBF, 8'hBD, 8'hF5, 8'h80, 8'h80, 8'h80}; send_text();
    // Sequences cut off by the end mark
    text_q = {8'hF0};                           send_text();
    text_q = {8'hE2, 8'h82};                    send_text();

    base = bytes_sent;
    while (bytes_sent - base < RandomBytes) begin
      if (!paused && bytes_sent - base >= RandomBytes / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      compose_text();
      send_text();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d bytes in %0d texts; checked %0d results, %0d flagged invalid.",
             bytes_sent, texts_sent, results, rejects);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/u8pd_pkg.sv
src/u8pd_check.sv
src/utf8_printable_decoder.sv
src/u8pd_checker.sv
verif/u8pd_checker.sv
verif/tb_utf8_printable_decoder.sv
